// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define SEGI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true outside reset
`define SEGI_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SEGI_ASSERT(lbl, clk, rstn, prop, msg)
`define SEGI_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== hdl/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// segi_pkg
// widths, constants and shared types of the segment intersection pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package segi_pkg;

	localparam int CW     = 32;          // coordinate
	localparam int DW     = 18;          // direction component
	localparam int LW     = 31;          // segment length
	localparam int EW     = 32;          // parallel threshold
	localparam int SXW    = CW + 1;      // start difference
	localparam int KPW    = 2 * DW;      // direction cross product term
	localparam int KW     = KPW + 1;     // denominator
	localparam int MPW    = DW + SXW;    // numerator term
	localparam int MW     = MPW + 1;     // numerator
	localparam int LLW    = 2 * LW;      // length product
	localparam int UAW    = LW + KW;     // length times denominator
	localparam int CMW    = LLW + KW;    // full denominator magnitude
	localparam int MSPLIT = MW / 2;      // numerator split for offset product
	localparam int PXW    = DW + MSPLIT; // partial offset product
	localparam int NW     = DW + MW;     // divider dividend
	localparam int DIV_STEP = 4;         // quotient bits per divider stage

	localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [EW-1:0] EPS_RESET = EW'(1);

	typedef struct packed {
		logic                 hit;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
	} div_side_t;

endpackage

`default_nettype wire

// ===== hdl/segi_div.sv =====
// ----------------------------------------------------------------------------
// segi_div
// two-lane pipelined restoring divider with a shared divisor and sideband
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segi_div #(
	parameter int QBITS = 36,
	parameter int STEP  = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [segi_pkg::NW-1:0]     num_x,
	input  logic [segi_pkg::NW-1:0]     num_y,
	input  logic [segi_pkg::KW-1:0]     den,
	input  segi_pkg::div_side_t         side_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [QBITS-1:0]            quo_x,
	output logic [QBITS-1:0]            quo_y,
	output segi_pkg::div_side_t         side_out
);
	import segi_pkg::*;

	localparam int NSTG = QBITS / STEP;
	localparam int AW   = KW + QBITS;

	logic [NSTG-1:0] v_s;
	logic [NSTG:0]   en;
	logic [AW-1:0]   acx_s  [NSTG];
	logic [AW-1:0]   acy_s  [NSTG];
	logic [KW-1:0]   den_s  [NSTG];
	div_side_t       side_s [NSTG];
	logic [AW-1:0]   acx_i  [NSTG];
	logic [AW-1:0]   acy_i  [NSTG];
	logic [KW-1:0]   den_i  [NSTG];
	div_side_t       side_i [NSTG];
	logic [AW-1:0]   acx_n  [NSTG];
	logic [AW-1:0]   acy_n  [NSTG];

	function automatic logic [AW-1:0] div_steps(input logic [AW-1:0] acc, input logic [KW-1:0] d);
		logic [KW:0]      t;
		logic [KW-1:0]    r;
		logic [QBITS-1:0] l;
		r = acc[AW-1:QBITS];
		l = acc[QBITS-1:0];
		for (int i = 0; i < STEP; i++) begin
			t = {r, l[QBITS-1]};
			l = {l[QBITS-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				l[0] = 1'b1;
			end
			r = t[KW-1:0];
		end
		return {r, l};
	endfunction

	assign en[NSTG] = !out_stall;
	assign in_stall = !en[0];

	for (genvar j = 0; j < NSTG; j++) begin : g_stage
		assign en[j] = !v_s[j] || en[j+1];

		if (j == 0) begin : g_head
			assign acx_i[j]  = {KW'(num_x >> QBITS), num_x[QBITS-1:0]};
			assign acy_i[j]  = {KW'(num_y >> QBITS), num_y[QBITS-1:0]};
			assign den_i[j]  = den;
			assign side_i[j] = side_in;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j] <= 1'b0;
				end else if (en[j]) begin
					v_s[j] <= in_valid;
				end
			end
		end else begin : g_body
			assign acx_i[j]  = acx_s[j-1];
			assign acy_i[j]  = acy_s[j-1];
			assign den_i[j]  = den_s[j-1];
			assign side_i[j] = side_s[j-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j] <= 1'b0;
				end else if (en[j]) begin
					v_s[j] <= v_s[j-1];
				end
			end
		end

		always_comb begin
			acx_n[j] = div_steps(acx_i[j], den_i[j]);
			acy_n[j] = div_steps(acy_i[j], den_i[j]);
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				acx_s[j]  <= acx_n[j];
				acy_s[j]  <= acy_n[j];
				den_s[j]  <= den_i[j];
				side_s[j] <= side_i[j];
			end
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign quo_x     = acx_s[NSTG-1][QBITS-1:0];
	assign quo_y     = acy_s[NSTG-1][QBITS-1:0];
	assign side_out  = side_s[NSTG-1];

	`SEGI_ASSERT(a_div_full, clk, arst_n, in_stall |-> out_valid && out_stall, "divider stalls input while not full")
	`SEGI_NEVER(a_div_drain, clk, arst_n, in_stall && !out_stall, "divider stalls input while output drains")
	`SEGI_ASSERT(a_div_take, clk, arst_n, in_valid && !in_stall |=> v_s[0], "divider lost an accepted word")

endmodule

`default_nettype wire

// ===== hdl/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d
// 2d segment/segment intersection test in signed fixed point
// ----------------------------------------------------------------------------
// input channel: one word per segment pair (start, unit direction, length
// of each segment), taken on in_valid high with in_stall low.
// output channel: hit flag and intersection point, given on out_valid and
// held while out_stall is high; the point reads zero on a miss.
// cfg_wr_en writes parallel_epsilon from cfg_wr_data; the user must write it
// only while idle, as the block itself does not enforce this. throughput:
// one word per cycle while out_stall is low, set by the quotient pipeline
// that retires four bits per stage for both coordinates.
// each stage holds its word under stall and takes a new one as soon as it
// empties, so bubbles close up while the receiver stalls.
// reset empties every stage and sets parallel_epsilon to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [segi_pkg::EW-1:0]            cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [segi_pkg::CW-1:0]     first_start_x,
	input  logic signed [segi_pkg::CW-1:0]     first_start_y,
	input  logic signed [segi_pkg::DW-1:0]     first_dir_x,
	input  logic signed [segi_pkg::DW-1:0]     first_dir_y,
	input  logic [segi_pkg::LW-1:0]            first_length,
	input  logic signed [segi_pkg::CW-1:0]     second_start_x,
	input  logic signed [segi_pkg::CW-1:0]     second_start_y,
	input  logic signed [segi_pkg::DW-1:0]     second_dir_x,
	input  logic signed [segi_pkg::DW-1:0]     second_dir_y,
	input  logic [segi_pkg::LW-1:0]            second_length,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic signed [segi_pkg::CW-1:0]     cross_x,
	output logic signed [segi_pkg::CW-1:0]     cross_y
);
	import segi_pkg::*;

	localparam int QW   = 49 - FRAC_BITS;
	localparam int DSTG = (QW + DIV_STEP - 1) / DIV_STEP;
	localparam int QP   = DSTG * DIV_STEP;
	localparam int RW   = (QP > CW) ? QP + 2 : CW + 2;
	localparam int CPW  = (MW + FRAC_BITS > UAW) ? MW + FRAC_BITS : UAW;

	function automatic logic [CW-1:0] sat_coord(input logic [RW-1:0] v);
		logic over;
		logic under;
		over  = !v[RW-1] && (|v[RW-2:CW-1]);
		under = v[RW-1] && !(&v[RW-2:CW-1]);
		if (over) begin
			return COORD_MAX;
		end else if (under) begin
			return COORD_MIN;
		end
		return v[CW-1:0];
	endfunction

	logic [EW-1:0] eps_q;

	logic en1, en2, en3, en4, en5, en6, en7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1
	logic signed [SXW-1:0] sx_s1, sy_s1;
	logic signed [KPW-1:0] pk1_s1, pk2_s1;
	logic [LLW-1:0]        lalb_s1;
	logic signed [CW-1:0]  ax_s1, ay_s1;
	logic signed [DW-1:0]  dax_s1, day_s1, dbx_s1, dby_s1;
	logic [LW-1:0]         la_s1, lb_s1;

	// stage 2
	logic signed [KW-1:0]  k_s2;
	logic signed [MPW-1:0] pm1_s2, pm2_s2, pn1_s2, pn2_s2;
	logic [LLW-1:0]        lalb_s2;
	logic signed [CW-1:0]  ax_s2, ay_s2;
	logic signed [DW-1:0]  dax_s2, day_s2;
	logic [LW-1:0]         la_s2, lb_s2;

	// stage 3
	logic signed [MW-1:0]  m_s3, n_s3;
	logic [KW-1:0]         kmag_s3;
	logic                  kneg_s3, knz_s3, lnz_s3;
	logic [LLW-1:0]        lalb_s3;
	logic signed [CW-1:0]  ax_s3, ay_s3;
	logic signed [DW-1:0]  dax_s3, day_s3;
	logic [LW-1:0]         la_s3, lb_s3;

	// stage 4
	logic [MW-1:0]         mmag_s4, nmag_s4;
	logic                  mneg_s4, nneg_s4, mnz_s4, nnz_s4;
	logic [DW-1:0]         dxmag_s4, dymag_s4;
	logic                  dxneg_s4, dyneg_s4;
	logic [UAW-1:0]        cpl_s4, cph_s4, ua_s4, ub_s4;
	logic [KW-1:0]         kmag_s4;
	logic                  kneg_s4, okb_s4;
	logic signed [CW-1:0]  ax_s4, ay_s4;

	// stage 5
	logic [CMW-1:0]        cmag_s5;
	logic                  inm_s5, inn_s5;
	logic [PXW-1:0]        pxl_s5, pxh_s5, pyl_s5, pyh_s5;
	logic                  negx_s5, negy_s5, okb_s5;
	logic [KW-1:0]         kmag_s5;
	logic signed [CW-1:0]  ax_s5, ay_s5;

	// stage 6
	logic                  hit_s6, negx_s6, negy_s6;
	logic [NW-1:0]         nx_s6, ny_s6;
	logic [KW-1:0]         kmag_s6;
	logic signed [CW-1:0]  ax_s6, ay_s6;

	// divider
	div_side_t             side_d_in, side_d_out;
	logic                  d_in_stall, d_out_valid;
	logic [QP-1:0]         d_quo_x, d_quo_y;

	// stage 7
	logic                  hit_s7;
	logic [CW-1:0]         cx_s7, cy_s7;
	logic [RW-1:0]         qx_ext, qy_ext, offx, offy, stx, sty, sumx, sumy;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// handshake chain
	assign en7      = !v_s7 || !out_stall;
	assign en6      = !v_s6 || !d_in_stall;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= d_out_valid;
		end
	end

	// stage 1: offsets, direction products, length product
	always_ff @(posedge clk) begin
		if (en1) begin
			sx_s1   <= {first_start_x[CW-1], first_start_x} - {second_start_x[CW-1], second_start_x};
			sy_s1   <= {first_start_y[CW-1], first_start_y} - {second_start_y[CW-1], second_start_y};
			pk1_s1  <= first_dir_x * second_dir_y;
			pk2_s1  <= second_dir_x * first_dir_y;
			lalb_s1 <= first_length * second_length;
			ax_s1   <= first_start_x;
			ay_s1   <= first_start_y;
			dax_s1  <= first_dir_x;
			day_s1  <= first_dir_y;
			dbx_s1  <= second_dir_x;
			dby_s1  <= second_dir_y;
			la_s1   <= first_length;
			lb_s1   <= second_length;
		end
	end

	// stage 2: denominator, numerator products
	always_ff @(posedge clk) begin
		if (en2) begin
			k_s2    <= {pk1_s1[KPW-1], pk1_s1} - {pk2_s1[KPW-1], pk2_s1};
			pm1_s2  <= dbx_s1 * sy_s1;
			pm2_s2  <= dby_s1 * sx_s1;
			pn1_s2  <= dax_s1 * sy_s1;
			pn2_s2  <= day_s1 * sx_s1;
			lalb_s2 <= lalb_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			dax_s2  <= dax_s1;
			day_s2  <= day_s1;
			la_s2   <= la_s1;
			lb_s2   <= lb_s1;
		end
	end

	// stage 3: numerators, denominator magnitude
	always_ff @(posedge clk) begin
		if (en3) begin
			m_s3    <= {pm1_s2[MPW-1], pm1_s2} - {pm2_s2[MPW-1], pm2_s2};
			n_s3    <= {pn1_s2[MPW-1], pn1_s2} - {pn2_s2[MPW-1], pn2_s2};
			kmag_s3 <= k_s2[KW-1] ? KW'(~k_s2 + 1'b1) : KW'(k_s2);
			kneg_s3 <= k_s2[KW-1];
			knz_s3  <= k_s2 != '0;
			lnz_s3  <= (la_s2 != '0) && (lb_s2 != '0);
			lalb_s3 <= lalb_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			dax_s3  <= dax_s2;
			day_s3  <= day_s2;
			la_s3   <= la_s2;
			lb_s3   <= lb_s2;
		end
	end

	// stage 4: magnitudes, bound products
	always_ff @(posedge clk) begin
		if (en4) begin
			mmag_s4  <= m_s3[MW-1] ? MW'(~m_s3 + 1'b1) : MW'(m_s3);
			nmag_s4  <= n_s3[MW-1] ? MW'(~n_s3 + 1'b1) : MW'(n_s3);
			mneg_s4  <= m_s3[MW-1];
			nneg_s4  <= n_s3[MW-1];
			mnz_s4   <= m_s3 != '0;
			nnz_s4   <= n_s3 != '0;
			dxmag_s4 <= dax_s3[DW-1] ? DW'(~dax_s3 + 1'b1) : DW'(dax_s3);
			dymag_s4 <= day_s3[DW-1] ? DW'(~day_s3 + 1'b1) : DW'(day_s3);
			dxneg_s4 <= dax_s3[DW-1];
			dyneg_s4 <= day_s3[DW-1];
			cpl_s4   <= lalb_s3[LW-1:0] * kmag_s3;
			cph_s4   <= lalb_s3[LLW-1:LW] * kmag_s3;
			ua_s4    <= la_s3 * kmag_s3;
			ub_s4    <= lb_s3 * kmag_s3;
			kmag_s4  <= kmag_s3;
			kneg_s4  <= kneg_s3;
			okb_s4   <= knz_s3 && lnz_s3;
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
		end
	end

	// stage 5: full denominator, parameter range tests, offset partials
	always_ff @(posedge clk) begin
		if (en5) begin
			cmag_s5 <= CMW'(cpl_s4) + (CMW'(cph_s4) << LW);
			inm_s5  <= !mnz_s4 || ((mneg_s4 == kneg_s4) &&
				((CPW'(mmag_s4) << FRAC_BITS) <= CPW'(ua_s4)));
			inn_s5  <= !nnz_s4 || ((nneg_s4 == kneg_s4) &&
				((CPW'(nmag_s4) << FRAC_BITS) <= CPW'(ub_s4)));
			pxl_s5  <= dxmag_s4 * mmag_s4[MSPLIT-1:0];
			pxh_s5  <= dxmag_s4 * mmag_s4[MW-1:MSPLIT];
			pyl_s5  <= dymag_s4 * mmag_s4[MSPLIT-1:0];
			pyh_s5  <= dymag_s4 * mmag_s4[MW-1:MSPLIT];
			negx_s5 <= dxneg_s4 ^ mneg_s4 ^ kneg_s4;
			negy_s5 <= dyneg_s4 ^ mneg_s4 ^ kneg_s4;
			okb_s5  <= okb_s4;
			kmag_s5 <= kmag_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
		end
	end

	// stage 6: parallel test, hit decision, dividends
	always_ff @(posedge clk) begin
		if (en6) begin
			hit_s6  <= okb_s5 && inm_s5 && inn_s5 &&
				((cmag_s5 >> (2 * FRAC_BITS)) >= CMW'(eps_q));
			nx_s6   <= NW'(pxl_s5) + (NW'(pxh_s5) << MSPLIT);
			ny_s6   <= NW'(pyl_s5) + (NW'(pyh_s5) << MSPLIT);
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			kmag_s6 <= kmag_s5;
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
		end
	end

	always_comb begin
		side_d_in.hit     = hit_s6;
		side_d_in.neg_x   = negx_s6;
		side_d_in.neg_y   = negy_s6;
		side_d_in.start_x = ax_s6;
		side_d_in.start_y = ay_s6;
	end

	segi_div #(
		.QBITS (QP),
		.STEP  (DIV_STEP)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_stall  (d_in_stall),
		.num_x     (nx_s6),
		.num_y     (ny_s6),
		.den       (kmag_s6),
		.side_in   (side_d_in),
		.out_valid (d_out_valid),
		.out_stall (!en7),
		.quo_x     (d_quo_x),
		.quo_y     (d_quo_y),
		.side_out  (side_d_out)
	);

	// stage 7: point = start + signed offset, saturated
	always_comb begin
		qx_ext = RW'(d_quo_x);
		qy_ext = RW'(d_quo_y);
		offx   = side_d_out.neg_x ? RW'(~qx_ext + 1'b1) : qx_ext;
		offy   = side_d_out.neg_y ? RW'(~qy_ext + 1'b1) : qy_ext;
		stx    = {{(RW-CW){side_d_out.start_x[CW-1]}}, side_d_out.start_x};
		sty    = {{(RW-CW){side_d_out.start_y[CW-1]}}, side_d_out.start_y};
		sumx   = stx + offx;
		sumy   = sty + offy;
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			hit_s7 <= side_d_out.hit;
			cx_s7  <= side_d_out.hit ? sat_coord(sumx) : '0;
			cy_s7  <= side_d_out.hit ? sat_coord(sumy) : '0;
		end
	end

	assign out_valid = v_s7;
	assign hit       = hit_s7;
	assign cross_x   = cx_s7;
	assign cross_y   = cy_s7;

	`SEGI_ASSERT(a_stall_full, clk, arst_n, in_stall |-> v_s1, "input stalled with empty first stage")
	`SEGI_ASSERT(a_miss_zero, clk, arst_n, out_valid && !hit |-> cross_x == '0 && cross_y == '0, "miss word carries a point")
	`SEGI_ASSERT(a_hit_den, clk, arst_n, v_s6 && hit_s6 |-> kmag_s6 != '0, "hit with zero denominator")

endmodule

`default_nettype wire

// ===== tb/tb_segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// tb_segment_intersection_2d
// self-checking bench for the 2d segment intersection pipeline
// ----------------------------------------------------------------------------
// a short table of directed segment pairs is run first. rows with an obvious
// answer carry it typed in, and the rest are checked against a predictor
// that uses exact wide integer math. random pairs follow, mostly built to
// cross at a chosen point, in phases with different parallel thresholds.
// the sender runs in bursts and the receiver stalls in a pattern of its own,
// with one long hold that backs the pipeline up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_intersection_2d;
	import segi_pkg::*;

	localparam longint ONE = 65536;
	localparam int SETTLE = 24;
	localparam int WATCHDOG = 3000;

	typedef struct {
		logic signed [CW-1:0] fsx, fsy;
		logic signed [DW-1:0] fdx, fdy;
		logic [LW-1:0]        flen;
		logic signed [CW-1:0] ssx, ssy;
		logic signed [DW-1:0] sdx, sdy;
		logic [LW-1:0]        slen;
	} pair_t;

	typedef struct {
		logic                 hit;
		logic signed [CW-1:0] cx, cy;
	} crossing_t;

	typedef struct {
		pair_t     p;
		bit        typed;
		crossing_t r;
	} pair_row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [EW-1:0] cfg_wr_data = '0;
	logic in_valid = 0, out_stall = 0;
	logic signed [CW-1:0] first_start_x = 0, first_start_y = 0;
	logic signed [CW-1:0] second_start_x = 0, second_start_y = 0;
	logic signed [DW-1:0] first_dir_x = 0, first_dir_y = 0;
	logic signed [DW-1:0] second_dir_x = 0, second_dir_y = 0;
	logic [LW-1:0] first_length = 0, second_length = 0;
	wire in_stall, out_valid, hit;
	wire signed [CW-1:0] cross_x, cross_y;

	segment_intersection_2d dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_dir_x(first_dir_x), .first_dir_y(first_dir_y),
		.first_length(first_length),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_dir_x(second_dir_x), .second_dir_y(second_dir_y),
		.second_length(second_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .cross_x(cross_x), .cross_y(cross_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	pair_row_t pair_q[$];
	crossing_t crossing_q[$];
	pair_row_t driven;
	logic [EW-1:0] threshold = EPS_RESET;
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0, gap_left = 0;
	logic hold = 0, hold_go = 0;

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	localparam int FRAC_SHIFT = 16;

	// num / (len * den) * 2^16 in [0,1]
	function automatic bit param_in_unit(longint num, longint len, longint den);
		logic [127:0] top, bot;
		if (num == 0)
			return 1;
		if ((num < 0) != (den < 0))
			return 0;
		top = {64'b0, mag(num)} << FRAC_SHIFT;
		bot = {64'b0, 64'(len)} * {64'b0, mag(den)};
		return top <= bot;
	endfunction

	function automatic logic [CW-1:0] crossing_coord(longint start, longint dir,
		longint num, longint den);
		logic [127:0] q;
		logic [63:0] qm;
		longint off, r;
		q = ({64'b0, mag(dir)} * {64'b0, mag(num)}) / {64'b0, mag(den)};
		qm = (q > (128'd1 << 62)) ? (64'd1 << 62) : q[63:0];
		off = (((dir < 0) != (num < 0)) != (den < 0)) ? -longint'(qm) : longint'(qm);
		r = start + off;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[CW-1:0];
	endfunction

	function automatic crossing_t predict_crossing(pair_t p, logic [EW-1:0] eps);
		longint ax, ay, dax, day, bx, by, dbx, dby, la, lb, sx, sy, k, m, n;
		logic [127:0] cmag, thr;
		crossing_t r;
		ax = p.fsx; ay = p.fsy; dax = p.fdx; day = p.fdy; la = p.flen;
		bx = p.ssx; by = p.ssy; dbx = p.sdx; dby = p.sdy; lb = p.slen;
		sx = ax - bx;
		sy = ay - by;
		k = dax * dby - dbx * day;
		m = dbx * sy - dby * sx;
		n = dax * sy - day * sx;
		r = '{0, 0, 0};
		if (k != 0 && la != 0 && lb != 0) begin
			cmag = {64'b0, 64'(la * lb)} * {64'b0, mag(k)};
			thr = {96'b0, eps} << (2 * FRAC_SHIFT);
			if (thr <= cmag && param_in_unit(m, la, k) && param_in_unit(n, lb, k)) begin
				r.hit = 1;
				r.cx = crossing_coord(ax, dax, m, k);
				r.cy = crossing_coord(ay, day, m, k);
			end
		end
		return r;
	endfunction

	// sender: bursts with gaps, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				idle_cycles = 0;
				crossing_q.push_back(driven.typed ? driven.r : predict_crossing(driven.p, threshold));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (pair_q.size() > 0) begin
					driven = pair_q.pop_front();
					first_start_x <= driven.p.fsx;
					first_start_y <= driven.p.fsy;
					first_dir_x <= driven.p.fdx;
					first_dir_y <= driven.p.fdy;
					first_length <= driven.p.flen;
					second_start_x <= driven.p.ssx;
					second_start_y <= driven.p.ssy;
					second_dir_x <= driven.p.sdx;
					second_dir_y <= driven.p.sdy;
					second_length <= driven.p.slen;
					in_valid <= 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stall pattern
	int stall_mode = 0, stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= hold;
			1: out_stall <= hold | ($urandom_range(0, 9) < 3);
			default: out_stall <= hold | ($urandom_range(0, 9) < 8);
		endcase
	end

	// long receiver hold while the sender keeps offering words
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold <= 1;
		repeat (400) @(posedge clk);
		hold <= 0;
	end

	// result check
	always @(posedge clk) begin
		crossing_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			idle_cycles = 0;
			if (crossing_q.size() == 0) begin
				$display("%0t: unexpected word hit=%0b x=%0d y=%0d", $time, hit, cross_x, cross_y);
				errors++;
			end else begin
				exp_r = crossing_q.pop_front();
				if (hit !== exp_r.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
					errors++;
				end
				if (cross_x !== exp_r.cx) begin
					$display("%0t: cross_x expected %0d actual %0d", $time, exp_r.cx, cross_x);
					errors++;
				end
				if (cross_y !== exp_r.cy) begin
					$display("%0t: cross_y expected %0d actual %0d", $time, exp_r.cy, cross_y);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic drain();
		while (pair_q.size() > 0 || in_valid || crossing_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(logic [EW-1:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		threshold = v;
	endtask

	function automatic logic signed [DW-1:0] rand_dir(bit full);
		if (full)
			return DW'($urandom_range(0, (1 << DW) - 1));
		return DW'(int'($urandom_range(0, 2 * ONE)) - int'(ONE));
	endfunction

	// pair built to cross near a random point, or noise
	function automatic pair_t rand_pair();
		pair_t p;
		longint px, py, la, lb, fa, fb;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			p = '{$urandom, $urandom, rand_dir(1), rand_dir(1), LW'($urandom),
				$urandom, $urandom, rand_dir(1), rand_dir(1), LW'($urandom)};
			return p;
		end
		px = longint'(int'($urandom)) >>> $urandom_range(2, 8);
		py = longint'(int'($urandom)) >>> $urandom_range(2, 8);
		la = (kind == 9) ? $urandom_range(1, 32'h7fffffff) : $urandom_range(1, 1 << 22);
		lb = (kind == 9) ? $urandom_range(1, 32'h7fffffff) : $urandom_range(1, 1 << 22);
		fa = $urandom_range(0, ONE + 2000);
		fb = $urandom_range(0, ONE + 2000);
		p.fdx = rand_dir(kind == 8);
		p.fdy = rand_dir(kind == 8);
		p.sdx = rand_dir(kind == 8);
		p.sdy = rand_dir(kind == 8);
		if (kind == 7) begin
			p.sdx = p.fdx;
			p.sdy = p.fdy;
		end
		p.flen = la;
		p.slen = lb;
		if ($urandom_range(0, 30) == 0)
			p.flen = 0;
		p.fsx = CW'(px - ((longint'(p.fdx) * la * fa) >>> 32));
		p.fsy = CW'(py - ((longint'(p.fdy) * la * fa) >>> 32));
		p.ssx = CW'(px - ((longint'(p.sdx) * lb * fb) >>> 32));
		p.ssy = CW'(py - ((longint'(p.sdy) * lb * fb) >>> 32));
		return p;
	endfunction

	pair_row_t directed[] = '{
		// zero length first, zero length second
		'{'{0, 0, ONE, 0, 0, 0, 0, 0, ONE, ONE}, 1, '{0, 0, 0}},
		'{'{0, 0, ONE, 0, ONE, 0, 0, 0, ONE, 0}, 1, '{0, 0, 0}},
		// parallel and collinear overlap
		'{'{0, 0, ONE, 0, 2*ONE, 0, ONE, ONE, 0, 2*ONE}, 1, '{0, 0, 0}},
		'{'{0, 0, ONE, 0, 2*ONE, ONE, 0, ONE, 0, 2*ONE}, 1, '{0, 0, 0}},
		'{'{0, 0, -ONE, 0, 2*ONE, ONE, 0, ONE, 0, 2*ONE}, 1, '{0, 0, 0}},
		// plain cross and endpoint touch
		'{'{0, 0, ONE, 0, 2*ONE, ONE, -ONE, 0, ONE, 2*ONE}, 1, '{1, ONE, 0}},
		'{'{0, 0, ONE, 0, ONE, ONE, -ONE, 0, ONE, ONE}, 1, '{1, ONE, 0}},
		'{'{0, 0, ONE, 0, ONE, ONE + 1, -ONE, 0, ONE, 2*ONE}, 0, '{0, 0, 0}},
		'{'{0, 0, ONE, 0, 2*ONE, ONE, -ONE, 0, ONE, ONE - 1}, 0, '{0, 0, 0}},
		'{'{0, 0, -ONE, 0, 2*ONE, -ONE, ONE, 0, -ONE, 2*ONE}, 0, '{0, 0, 0}},
		// direction extremes, not of unit length
		'{'{0, 0, 18'h1ffff, 18'h20000, 4*ONE, 3*ONE, 0, 18'h20000, 18'h1ffff, 4*ONE}, 0,
			'{0, 0, 0}},
		'{'{5, -7, 18'h20000, 18'h20000, 31'h7fffffff, 0, 0, 18'h1ffff, 18'h20001, 31'h7fffffff},
			0, '{0, 0, 0}},
		// start and length extremes, saturating points
		'{'{32'h7fffffff, 32'h7fffffff, ONE, ONE, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
			ONE, -ONE, 31'h7fffffff}, 0, '{0, 0, 0}},
		'{'{32'h80000000, 32'h80000000, ONE, ONE, 31'h7fffffff, 32'h7fffffff, 32'h80000000,
			-ONE, ONE, 31'h7fffffff}, 0, '{0, 0, 0}},
		'{'{32'h7fff0000, 0, 18'h1ffff, 1, 31'h7fffffff, 32'h7fff0000, 32'h80000000,
			18'h1ffff, 18'h1ffff, 31'h7fffffff}, 0, '{0, 0, 0}},
		'{'{32'h80000000, 0, 18'h20000, -1, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
			18'h20000, 18'h20000, 31'h7fffffff}, 0, '{0, 0, 0}},
		'{'{-3*ONE, -ONE, ONE, 0, 6*ONE, 0, -4*ONE, 46341, 46341, 8*ONE}, 0, '{0, 0, 0}}
	};

	initial begin
		logic [EW-1:0] eps_set[4];
		pair_row_t row;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			pair_q.push_back(directed[i]);
		eps_set = '{32'd0, 32'hffffffff, $urandom, 32'd1 << $urandom_range(0, 31)};
		for (int ph = 0; ph < 4; ph++) begin
			write_threshold(eps_set[ph]);
			for (int i = 0; i < 400; i++) begin
				row.p = rand_pair();
				row.typed = 0;
				row.r = '{0, 0, 0};
				pair_q.push_back(row);
			end
			if (ph == 2) begin
				while (pair_q.size() > 300)
					@(posedge clk);
				hold_go = 1;
			end
		end
		drain();
		if (errors == 0 && crossing_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
